@@ rtl/wcd_pkg.sv @@
// Shared types, constants and helpers for the waveform chunk decoder.
// No dependencies; imported by every module of the block and by wcd_result_if.
package wcd_pkg;

    localparam int unsigned MAX_POINTS   = 300000;
    localparam int unsigned POINT_W      = 19;
    localparam int unsigned VALUE_W      = 16;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] MAGIC_TAG    = "PMAI";
    localparam logic [31:0] WAVE_TAG_2B  = "PWV5";
    localparam logic [31:0] WAVE_TAG_1B  = "PWV3";

    localparam logic [31:0] FILE_HDR_LEN   = 32'd12;
    localparam logic [31:0] CHUNK_HDR_MIN  = 32'd12;
    localparam logic [31:0] WAVE_HDR_LEN   = 32'd24;

    localparam logic       KIND_POINT  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_FORMAT   = 2'd2;

    typedef struct packed {
        logic                has_point;
        logic [VALUE_W-1:0]  point_value;
        logic                has_status;
        logic [1:0]          status_code;
        logic [POINT_W-1:0]  point_count;
    } result_entry_t;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        return tag[{~idx, 3'b000} +: 8];
    endfunction

endpackage

@@ rtl/wcd_byte_if.sv @@
// Byte channel into the waveform chunk decoder: valid/ready plus one file byte.
// Depends on nothing.
interface wcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/wcd_result_if.sv @@
// Result channel out of the waveform chunk decoder: valid/ready plus result fields.
// Depends on wcd_pkg for field widths.
interface wcd_result_if
    import wcd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [VALUE_W-1:0] point_value;
    logic [POINT_W-1:0] point_count;
    logic [1:0]         status_code;
    logic               end_of_run;

    modport source (output valid, output result_kind, output point_value,
                    output point_count, output status_code, output end_of_run,
                    input ready);
    modport sink   (input valid, input result_kind, input point_value,
                    input point_count, input status_code, input end_of_run,
                    output ready);
endinterface

@@ rtl/wcd_parser.sv @@
// Input register, file/chunk walk state and point conversion for one byte per cycle.
// Depends on wcd_pkg; produces one queue entry per byte that yields a result.
module wcd_parser
    import wcd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wave_style,
    input  logic          byte_valid,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output logic          push,
    output result_entry_t entry
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_CHUNK  = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_POINTS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_last_reg;

    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        total_reg, total_next;
    logic [31:0]        cstart_reg, cstart_next;
    logic [31:0]        hlen_reg, hlen_next;
    logic [31:0]        clen_reg, clen_next;
    logic [31:0]        cend_reg, cend_next;
    logic [31:0]        fs_reg, fs_next;
    logic               tag_reg, tag_next;
    logic [POINT_W-1:0] left_reg, left_next;
    logic [POINT_W-1:0] ptotal_reg, ptotal_next;
    logic [7:0]         held_reg, held_next;
    logic [2:0]         phase_reg, phase_next;
    logic               found_reg, found_next;
    logic               err_reg, err_next;
    logic               style_reg, style_next;

    logic [31:0]        offset;
    logic [31:0]        shifted;
    logic [31:0]        walk_addr;
    logic [31:0]        walk_rest;
    logic [33:0]        need;
    logic [15:0]        wword;
    logic [POINT_W-1:0] left_dec;
    logic [1:0]         code;
    logic               style_eff;
    logic               fail_req;
    logic               walk_req;
    logic               bad;
    result_entry_t      entry_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        total_next  = total_reg;
        cstart_next = cstart_reg;
        hlen_next   = hlen_reg;
        clen_next   = clen_reg;
        cend_next   = cend_reg;
        fs_next     = fs_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        ptotal_next = ptotal_reg;
        held_next   = held_reg;
        phase_next  = phase_reg;
        found_next  = found_reg;
        err_next    = err_reg;
        fail_req    = 1'b0;
        walk_req    = 1'b0;
        walk_addr   = cstart_reg;
        walk_rest   = '0;
        need        = '0;
        wword       = {held_reg, s1_byte_reg};
        left_dec    = left_reg - POINT_W'(left_reg != '0);
        entry_c     = '0;
        code        = ST_OK;
        bad         = 1'b0;

        offset    = pos_reg - cstart_reg;
        shifted   = {fs_reg[23:0], s1_byte_reg};
        style_eff = (pos_reg == '0) ? wave_style : style_reg;
        style_next = style_eff;

        if (phase_reg == PH_SKIP && pos_reg == cstart_reg)
        begin
            phase_next = PH_CHUNK;
            tag_next   = 1'b1;
        end

        unique case (phase_next)
            PH_HEADER:
            begin
                if (pos_reg < 32'd4)
                begin
                    if (s1_byte_reg != tag_byte(MAGIC_TAG, pos_reg[1:0]))
                    begin
                        fail_req = 1'b1;
                    end
                end
                else
                begin
                    fs_next = shifted;
                    if (pos_reg == 32'd7)
                    begin
                        cstart_next = shifted;
                    end
                    if (pos_reg == 32'd11)
                    begin
                        total_next = shifted;
                        if (cstart_reg < FILE_HDR_LEN || cstart_reg > shifted)
                        begin
                            fail_req = 1'b1;
                        end
                        else
                        begin
                            walk_req  = 1'b1;
                            walk_addr = cstart_reg;
                        end
                    end
                end
            end
            PH_CHUNK:
            begin
                if (offset < 32'd4)
                begin
                    if (s1_byte_reg != tag_byte(style_eff ? WAVE_TAG_1B : WAVE_TAG_2B,
                                                offset[1:0]))
                    begin
                        tag_next = 1'b0;
                    end
                end
                else
                begin
                    fs_next = shifted;
                    if (offset == 32'd7)
                    begin
                        hlen_next = shifted;
                    end
                    if (offset == 32'd11)
                    begin
                        clen_next = shifted;
                        cend_next = cstart_reg + shifted;
                        if (hlen_reg < CHUNK_HDR_MIN || shifted < hlen_reg ||
                            shifted > total_reg - cstart_reg)
                        begin
                            fail_req = 1'b1;
                        end
                        else if (!tag_next)
                        begin
                            walk_req  = 1'b1;
                            walk_addr = cstart_reg + shifted;
                        end
                        else if (found_reg || hlen_reg != WAVE_HDR_LEN)
                        begin
                            fail_req = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_EXT;
                        end
                    end
                end
            end
            PH_EXT:
            begin
                fs_next = shifted;
                need = (style_eff ? {2'b00, shifted} : {1'b0, shifted, 1'b0})
                       + {2'b00, WAVE_HDR_LEN};
                if (offset == 32'd15 && shifted != (style_eff ? 32'd1 : 32'd2))
                begin
                    fail_req = 1'b1;
                end
                else if (offset == 32'd19)
                begin
                    if (shifted == '0 || shifted > 32'(MAX_POINTS) ||
                        need != {2'b00, clen_reg})
                    begin
                        fail_req = 1'b1;
                    end
                    else
                    begin
                        ptotal_next = shifted[POINT_W-1:0];
                        left_next   = shifted[POINT_W-1:0];
                        found_next  = 1'b1;
                    end
                end
                else if (offset == 32'd23)
                begin
                    phase_next = PH_POINTS;
                end
            end
            PH_POINTS:
            begin
                if (!style_eff && !offset[0])
                begin
                    held_next = s1_byte_reg;
                end
                else
                begin
                    entry_c.has_point = 1'b1;
                    if (style_eff)
                    begin
                        entry_c.point_value = {8'h00, s1_byte_reg[4:0], s1_byte_reg[7:5]};
                    end
                    else
                    begin
                        entry_c.point_value = {2'b00, wword[6:2], wword[9:7],
                                               wword[12:10], wword[15:13]};
                    end
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        walk_req  = 1'b1;
                        walk_addr = cend_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase

        walk_rest = total_next - walk_addr;
        if (walk_req)
        begin
            if (walk_addr == total_next)
            begin
                phase_next = PH_DONE;
            end
            else if (walk_rest < FILE_HDR_LEN)
            begin
                fail_req = 1'b1;
            end
            else
            begin
                cstart_next = walk_addr;
                phase_next  = PH_SKIP;
            end
        end
        if (fail_req)
        begin
            err_next   = 1'b1;
            phase_next = PH_DONE;
        end

        pos_next = pos_reg + 32'd1;

        if (s1_last_reg)
        begin
            bad = err_next || phase_next != PH_DONE || pos_next != total_next;
            if (bad)
            begin
                code = ST_FORMAT;
            end
            else if (found_next)
            begin
                code = ST_OK;
            end
            else
            begin
                code = ST_NO_MATCH;
            end
            entry_c.has_status  = 1'b1;
            entry_c.status_code = code;
            entry_c.point_count = (code == ST_OK) ? ptotal_next : '0;

            pos_next    = '0;
            total_next  = '0;
            cstart_next = '0;
            hlen_next   = '0;
            clen_next   = '0;
            cend_next   = '0;
            fs_next     = '0;
            tag_next    = 1'b1;
            left_next   = '0;
            ptotal_next = '0;
            held_next   = '0;
            phase_next  = PH_HEADER;
            found_next  = 1'b0;
            err_next    = 1'b0;
            style_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            total_reg  <= '0;
            cstart_reg <= '0;
            hlen_reg   <= '0;
            clen_reg   <= '0;
            cend_reg   <= '0;
            fs_reg     <= '0;
            tag_reg    <= 1'b1;
            left_reg   <= '0;
            ptotal_reg <= '0;
            held_reg   <= '0;
            phase_reg  <= PH_HEADER;
            found_reg  <= 1'b0;
            err_reg    <= 1'b0;
            style_reg  <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            cstart_reg <= cstart_next;
            hlen_reg   <= hlen_next;
            clen_reg   <= clen_next;
            cend_reg   <= cend_next;
            fs_reg     <= fs_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            ptotal_reg <= ptotal_next;
            held_reg   <= held_next;
            phase_reg  <= phase_next;
            found_reg  <= found_next;
            err_reg    <= err_next;
            style_reg  <= style_next;
        end
    end

    assign push  = s1_valid_reg && (entry_c.has_point || entry_c.has_status);
    assign entry = entry_c;

    a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> phase_reg == PH_DONE)
        else $error("error seen while walk still active");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |=> pos_reg == '0 && phase_reg == PH_HEADER)
        else $error("state not cleared after final byte");

    a_points_found: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_POINTS |-> found_reg && left_reg != '0)
        else $error("point phase without a counted chunk");

endmodule

@@ rtl/wcd_result_queue.sv @@
// Result queue: holds parser entries and splits a point-plus-status entry into two transactions.
// Depends on wcd_pkg for the entry type and queue sizing.
module wcd_result_queue
    import wcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  result_entry_t        entry,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [VALUE_W-1:0]   point_value,
    output logic [POINT_W-1:0]   point_count,
    output logic [1:0]           status_code,
    output logic                 end_of_run
);

    result_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg, count_next;
    logic                 sent_reg, sent_next;
    result_entry_t        head;
    logic                 show_point;
    logic                 take;
    logic                 pop;

    assign head       = mem_reg[rd_ptr_reg];
    assign show_point = head.has_point && !sent_reg;
    assign out_valid  = count_reg != '0;
    assign take       = out_valid && out_ready;
    assign pop        = take && !(show_point && head.has_status);

    assign result_kind = show_point ? KIND_POINT : KIND_STATUS;
    assign point_value = show_point ? head.point_value : '0;
    assign point_count = show_point ? '0 : head.point_count;
    assign status_code = show_point ? ST_OK : head.status_code;
    assign end_of_run  = !show_point;

    // one entry may sit in the parser input stage, so keep two slots free
    assign room = count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2);

    always_comb
    begin
        count_next = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
        sent_next  = sent_reg;
        if (pop)
        begin
            sent_next = 1'b0;
        end
        else if (take)
        begin
            sent_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sent_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
            sent_reg  <= sent_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg |-> out_valid && head.has_point && head.has_status)
        else $error("split flag set without a point-plus-status entry");

endmodule

@@ rtl/waveform_chunk_decoder_core.sv @@
// Path: each byte passes the parser input register; its entry then waits in the result queue.
// Throughput: one byte per cycle; a final byte that also completes a point takes two result
// transactions; byte ready drops while three or more entries wait in the 4-entry result queue.
// Reset: all walk state and the queue clear; wave_style resets to 0 and is sampled at the
// first byte of each file. Depends on wcd_pkg, wcd_byte_if, wcd_result_if, wcd_parser,
// wcd_result_queue.
module waveform_chunk_decoder_core
    import wcd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    wcd_byte_if.sink      byte_ch,
    wcd_result_if.source  result_ch
);

    logic          wave_style_reg;
    logic          room;
    logic          push;
    result_entry_t entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_style_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            wave_style_reg <= cfg_wdata;
        end
    end

    assign byte_ch.ready = room;

    wcd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .wave_style (wave_style_reg),
        .byte_valid (byte_ch.valid && room),
        .data_byte  (byte_ch.data_byte),
        .last_byte  (byte_ch.last_byte),
        .push       (push),
        .entry      (entry)
    );

    wcd_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .entry       (entry),
        .room        (room),
        .out_valid   (result_ch.valid),
        .out_ready   (result_ch.ready),
        .result_kind (result_ch.result_kind),
        .point_value (result_ch.point_value),
        .point_count (result_ch.point_count),
        .status_code (result_ch.status_code),
        .end_of_run  (result_ch.end_of_run)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for waveform_chunk_decoder_core: byte-wise analysis files in,
// points and final status out, checked against a built-in file-walk predictor.
// Depends on wcd_pkg, wcd_byte_if, wcd_result_if and the decoder RTL.
module tb
    import wcd_pkg::*;
;

    localparam int ITEM_GOAL  = 1550;
    localparam int FLAW_KINDS = 19;

    typedef enum logic [2:0] {
        SCAN_HEAD, SCAN_SKIP, SCAN_TAG, SCAN_EXT, SCAN_PTS, SCAN_DONE
    } scan_phase_t;

    typedef enum int {
        FLAW_NONE, FLAW_NO_MATCH, FLAW_MAGIC, FLAW_OFS_LOW, FLAW_OFS_HIGH,
        FLAW_SHORT_TAIL, FLAW_HDR_LOW, FLAW_LEN_LOW, FLAW_LEN_PAST, FLAW_DUP,
        FLAW_WAVE_HDR, FLAW_STRIDE, FLAW_CNT_ZERO, FLAW_CNT_OVER, FLAW_CNT_MAX,
        FLAW_CLEN, FLAW_EXTRA, FLAW_TRUNC, FLAW_NOISE
    } flaw_t;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic [POINT_W-1:0] count;
        logic [1:0]         status;
        logic               done;
    } wave_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic row_typed = 1'b0;
    logic [1:0] row_status = ST_OK;
    logic calm = 1'b0;
    int gap_odds = 0;
    int stall_odds = 4;
    int hold_left = 0;
    int mismatches = 0;
    int bytes_sent = 0;

    wcd_byte_if   byte_ch ();
    wcd_result_if result_ch ();

    waveform_chunk_decoder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .byte_ch   (byte_ch.sink),
        .result_ch (result_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // {typed, status, last, byte}
    logic [11:0] opening_rows [0:21] = '{
        {1'b0, ST_OK, 1'b0, "P"}, {1'b0, ST_OK, 1'b0, "M"},
        {1'b0, ST_OK, 1'b0, "A"}, {1'b0, ST_OK, 1'b0, "I"},
        {1'b0, ST_OK, 1'b0, 8'h00}, {1'b0, ST_OK, 1'b0, 8'h00},
        {1'b0, ST_OK, 1'b0, 8'h00}, {1'b0, ST_OK, 1'b0, 8'h0C},
        {1'b0, ST_OK, 1'b0, 8'h00}, {1'b0, ST_OK, 1'b0, 8'h00},
        {1'b0, ST_OK, 1'b0, 8'h00}, {1'b1, ST_NO_MATCH, 1'b1, 8'h0C},
        {1'b1, ST_FORMAT, 1'b1, 8'hFF},
        {1'b1, ST_FORMAT, 1'b1, 8'h00},
        {1'b0, ST_OK, 1'b0, "P"}, {1'b0, ST_OK, 1'b0, "M"},
        {1'b0, ST_OK, 1'b0, "A"}, {1'b1, ST_FORMAT, 1'b1, 8'h80},
        {1'b0, ST_OK, 1'b0, "P"}, {1'b0, ST_OK, 1'b0, "M"},
        {1'b0, ST_OK, 1'b0, "A"}, {1'b1, ST_FORMAT, 1'b1, "I"}
    };

    // walk predictor state
    logic        style_pick = 1'b0;
    logic        style_held;
    logic [31:0] pos_r, total_r, cstart_r, hdrlen_r, clen_r, shreg;
    logic        tag_ok, found_r, err_r;
    logic [18:0] left_r, total_pts;
    logic [7:0]  held_r;
    scan_phase_t phase;

    wave_result_t pending_results [$];
    logic [7:0]   file_q [$];

    task automatic clear_walk();
        pos_r = 0;
        total_r = 0;
        cstart_r = 0;
        hdrlen_r = 0;
        clen_r = 0;
        shreg = 0;
        tag_ok = 1'b1;
        left_r = 0;
        held_r = 0;
        phase = SCAN_HEAD;
        found_r = 1'b0;
        err_r = 1'b0;
        total_pts = 0;
        style_held = 1'b0;
    endtask

    task automatic abort_walk();
        err_r = 1'b1;
        phase = SCAN_DONE;
    endtask

    task automatic next_chunk(input logic [31:0] nxt);
        if (nxt == total_r)
            phase = SCAN_DONE;
        else if (total_r - nxt < FILE_HDR_LEN)
            abort_walk();
        else
        begin
            cstart_r = nxt;
            phase = SCAN_SKIP;
        end
    endtask

    task automatic emit_point(input logic [15:0] v);
        pending_results.push_back('{KIND_POINT, v, 19'd0, ST_OK, 1'b0});
        if (left_r != 0)
            left_r = left_r - 1'b1;
        if (left_r == 0)
            next_chunk(cstart_r + clen_r);
    endtask

    task automatic decode_file_byte(input logic [7:0] b, input logic is_last);
        logic [31:0] p, o, stride, tag;
        logic [63:0] need;
        logic [15:0] w;
        logic [1:0]  code;
        p = pos_r;
        o = p - cstart_r;
        if (p == 0)
            style_held = style_pick;
        stride = style_held ? 32'd1 : 32'd2;
        tag = style_held ? WAVE_TAG_1B : WAVE_TAG_2B;
        if (phase == SCAN_SKIP && p == cstart_r)
        begin
            phase = SCAN_TAG;
            tag_ok = 1'b1;
            o = 0;
        end
        case (phase)
            SCAN_HEAD:
                if (p < 4)
                begin
                    if (b != MAGIC_TAG[8*(3-p) +: 8])
                        abort_walk();
                end
                else
                begin
                    shreg = {shreg[23:0], b};
                    if (p == 7)
                        cstart_r = shreg;
                    if (p == 11)
                    begin
                        total_r = shreg;
                        if (cstart_r < FILE_HDR_LEN || cstart_r > total_r)
                            abort_walk();
                        else
                            next_chunk(cstart_r);
                    end
                end
            SCAN_TAG:
                if (o < 4)
                begin
                    if (b != tag[8*(3-o) +: 8])
                        tag_ok = 1'b0;
                end
                else
                begin
                    shreg = {shreg[23:0], b};
                    if (o == 7)
                        hdrlen_r = shreg;
                    if (o == 11)
                    begin
                        clen_r = shreg;
                        if (hdrlen_r < CHUNK_HDR_MIN || clen_r < hdrlen_r ||
                            clen_r > total_r - cstart_r)
                            abort_walk();
                        else if (!tag_ok)
                            next_chunk(cstart_r + clen_r);
                        else if (found_r || hdrlen_r != WAVE_HDR_LEN)
                            abort_walk();
                        else
                            phase = SCAN_EXT;
                    end
                end
            SCAN_EXT:
            begin
                shreg = {shreg[23:0], b};
                if (o == 15 && shreg != stride)
                    abort_walk();
                else if (o == 19)
                begin
                    need = {32'd0, shreg} * {32'd0, stride} + 64'd24;
                    if (shreg == 0 || shreg > MAX_POINTS || need != {32'd0, clen_r})
                        abort_walk();
                    else
                    begin
                        total_pts = shreg[18:0];
                        left_r = shreg[18:0];
                        found_r = 1'b1;
                    end
                end
                else if (o == 23)
                    phase = SCAN_PTS;
            end
            SCAN_PTS:
                if (style_held)
                    emit_point({8'd0, b[4:0], b[7:5]});
                else if (!o[0])
                    held_r = b;
                else
                begin
                    w = {held_r, b};
                    emit_point({2'b00, w[6:2], w[9:7], w[12:10], w[15:13]});
                end
            default: ;
        endcase
        pos_r = p + 1;
        if (is_last)
        begin
            code = (err_r || phase != SCAN_DONE || pos_r != total_r) ? ST_FORMAT :
                   (found_r ? ST_OK : ST_NO_MATCH);
            pending_results.push_back('{KIND_STATUS, 16'd0,
                                        (code == ST_OK) ? total_pts : 19'd0, code, 1'b1});
            clear_walk();
        end
    endtask

    always @(posedge clk)
    begin
        if (cfg_we)
            style_pick = cfg_wdata;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            decode_file_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (row_typed)
            begin
                pending_results.delete(pending_results.size() - 1);
                pending_results.push_back('{KIND_STATUS, 16'd0, 19'd0, row_status, 1'b1});
            end
        end
    end

    task automatic check_result(input wave_result_t got);
        wave_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d value %h count %0d status %0d end %0d",
                         got.kind, got.value, got.count, got.status, got.done);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch (exp/act): kind %0d/%0d value %h/%h count %0d/%0d",
                          " status %0d/%0d end %0d/%0d"},
                         want.kind, got.kind, want.value, got.value, want.count, got.count,
                         want.status, got.status, want.done, got.done);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result('{result_ch.result_kind, result_ch.point_value,
                           result_ch.point_count, result_ch.status_code,
                           result_ch.end_of_run});
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            hold_left = $urandom_range(1, 19) - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
        if ($urandom_range(0, 299) == 0)
            case ($urandom_range(0, 2))
                0: stall_odds = 0;
                1: stall_odds = 4;
                default: stall_odds = 12;
            endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input logic typed, input logic [1:0] st);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        row_typed <= typed;
        row_status <= st;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_file();
        case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 10;
        endcase
        foreach (file_q[i])
            send_byte(file_q[i], i == file_q.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic await_drain();
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_word(input logic [31:0] w);
        file_q.push_back(w[31:24]);
        file_q.push_back(w[23:16]);
        file_q.push_back(w[15:8]);
        file_q.push_back(w[7:0]);
    endtask

    task automatic patch_word(input int at, input logic [31:0] w);
        file_q[at]   = w[31:24];
        file_q[at+1] = w[23:16];
        file_q[at+2] = w[15:8];
        file_q[at+3] = w[7:0];
    endtask

    task automatic push_noise(input int n);
        repeat (n) file_q.push_back($urandom_range(0, 255));
    endtask

    task automatic add_wave_chunk(input logic sty, input flaw_t flaw,
                                  output logic [31:0] missing);
        logic [31:0] stride, count, clen, hdr, stride_word;
        int body;
        stride = sty ? 32'd1 : 32'd2;
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if (flaw == FLAW_CNT_ZERO)
            count = 0;
        else if (flaw == FLAW_CNT_OVER)
            count = $urandom_range(MAX_POINTS + 1, 2000000);
        else if (flaw == FLAW_CNT_MAX)
            count = MAX_POINTS;
        clen = count * stride + WAVE_HDR_LEN;
        if (flaw == FLAW_CLEN)
            clen = clen - 1;
        hdr = WAVE_HDR_LEN;
        if (flaw == FLAW_WAVE_HDR)
            hdr = $urandom_range(0, 1) ? $urandom_range(12, 23) : $urandom_range(25, 40);
        stride_word = (flaw == FLAW_STRIDE) ? stride + $urandom_range(1, 3) : stride;
        push_word(sty ? WAVE_TAG_1B : WAVE_TAG_2B);
        push_word(hdr);
        push_word(clen);
        push_word(stride_word);
        push_word(count);
        push_noise(4);
        body = (flaw == FLAW_CNT_OVER || flaw == FLAW_CNT_MAX) ?
               $urandom_range(1, 6) * stride : count * stride;
        push_noise(body);
        missing = (flaw == FLAW_CNT_OVER || flaw == FLAW_CNT_MAX) ?
                  clen - WAVE_HDR_LEN - body : 32'd0;
    endtask

    task automatic add_other_chunk(input logic sty);
        logic [31:0] tag, hdr, clen;
        case ($urandom_range(0, 2))
            0: tag = sty ? WAVE_TAG_2B : WAVE_TAG_1B;
            1: tag = (sty ? WAVE_TAG_1B : WAVE_TAG_2B) ^ (32'd1 << $urandom_range(0, 31));
            default: tag = $urandom;
        endcase
        hdr = $urandom_range(12, 20);
        clen = hdr + $urandom_range(0, 6);
        push_word(tag);
        push_word(hdr);
        push_word(clen);
        push_noise(clen - 12);
    endtask

    task automatic build_file(input logic sty, input flaw_t flaw);
        int gap, nchunks, wave_at, first_at, k;
        logic [31:0] ofs, total, virt, lost;
        file_q = {};
        virt = 0;
        if (flaw == FLAW_NOISE)
        begin
            if ($urandom_range(0, 1))
                push_word(MAGIC_TAG);
            push_noise($urandom_range(1, 24));
            return;
        end
        push_word(MAGIC_TAG);
        push_word(32'd0);
        push_word(32'd0);
        gap = $urandom_range(0, 3);
        push_noise(gap);
        first_at = file_q.size();
        nchunks = $urandom_range(1, 3);
        wave_at = (flaw == FLAW_CNT_OVER || flaw == FLAW_CNT_MAX) ?
                  nchunks - 1 : $urandom_range(0, nchunks - 1);
        for (int c = 0; c < nchunks; c++)
        begin
            if (c == wave_at && flaw != FLAW_NO_MATCH)
            begin
                add_wave_chunk(sty, flaw, lost);
                virt = lost;
            end
            else
                add_other_chunk(sty);
        end
        if (flaw == FLAW_DUP)
            add_wave_chunk(sty, FLAW_NONE, lost);
        if (flaw == FLAW_SHORT_TAIL)
            push_noise($urandom_range(1, 11));
        total = file_q.size() + virt;
        if (flaw == FLAW_EXTRA)
            push_noise($urandom_range(1, 5));
        ofs = FILE_HDR_LEN + gap;
        if (flaw == FLAW_OFS_LOW)
            ofs = $urandom_range(0, 11);
        else if (flaw == FLAW_OFS_HIGH)
            ofs = total + $urandom_range(1, 300);
        patch_word(4, ofs);
        patch_word(8, total);
        case (flaw)
            FLAW_MAGIC:
            begin
                k = $urandom_range(0, 3);
                file_q[k] = file_q[k] ^ (8'd1 << $urandom_range(0, 7));
            end
            FLAW_HDR_LOW:  patch_word(first_at + 4, $urandom_range(0, 11));
            FLAW_LEN_LOW:  patch_word(first_at + 8, $urandom_range(0, 11));
            FLAW_LEN_PAST: patch_word(first_at + 8, total - first_at + $urandom_range(1, 1000));
            FLAW_TRUNC:    repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
            default: ;
        endcase
    endtask

    initial
    begin
        int spins;
        int phase_no;
        int file_no;
        logic sty;
        flaw_t flaw;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'd0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready = 1'b0;
        clear_walk();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
            send_byte(opening_rows[i][7:0], opening_rows[i][8],
                      opening_rows[i][11], opening_rows[i][10:9]);
        byte_ch.valid <= 1'b0;

        phase_no = 0;
        file_no = 0;
        while (bytes_sent < ITEM_GOAL)
        begin
            // hold until every pending result is out, then switch style
            await_drain();
            sty = (phase_no % 2 == 0);
            cfg_wdata <= sty;
            cfg_we <= 1'b1;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (bytes_sent > ITEM_GOAL - 250)
                calm = 1'b1;
            repeat ($urandom_range(3, 6))
            begin
                if (file_no < FLAW_KINDS)
                    flaw = flaw_t'(file_no);
                else if ($urandom_range(0, 99) < 55)
                    flaw = FLAW_NONE;
                else
                    flaw = flaw_t'($urandom_range(1, FLAW_KINDS - 1));
                build_file(sty, flaw);
                send_file();
                file_no++;
            end
            byte_ch.valid <= 1'b0;
            phase_no++;
        end

        spins = 0;
        @(posedge clk);
        while (pending_results.size() != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/wcd_pkg.sv
rtl/wcd_byte_if.sv
rtl/wcd_result_if.sv
rtl/wcd_parser.sv
rtl/wcd_result_queue.sv
rtl/waveform_chunk_decoder_core.sv
tb/sv/tb.sv
